// ----- hdl/prime_factor_counter_top_assert.svh -----
// Assertion macros for the prime factor counter checker.
// Used by pfc_checker.sv only; no other dependencies.
`ifndef PRIME_FACTOR_COUNTER_TOP_ASSERT_SVH
`define PRIME_FACTOR_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfc assertion failed");

// Next-cycle implication, disabled in reset.
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfc assertion failed");

`endif

// ----- hdl/pfc_pkg.sv -----
// Shared types, constants and helper functions for the prime factor counter.
// No dependencies.
package pfc_pkg;

    localparam int ARG_W      = 31;   // width of value fields
    localparam int TOTAL_W    = 5;    // width of factor counts
    localparam int DISTINCT_W = 4;    // width of distinct counts

    localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = 5'd31;
    localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = 4'd15;
    localparam int                    FIRST_DIVISOR = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EVAL,
        S_FINISH,
        S_DONE
    } t_core_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [TOTAL_W-1:0]    factor_count;
        logic [DISTINCT_W-1:0] distinct_count;
    } t_core_stat;

    function automatic logic [TOTAL_W-1:0] inc_total(input logic [TOTAL_W-1:0] t);
        return (t == TOTAL_MAX) ? t : t + 1'b1;
    endfunction

    function automatic logic [DISTINCT_W-1:0] inc_distinct(
        input logic [DISTINCT_W-1:0] d);
        return (d == DISTINCT_MAX) ? d : d + 1'b1;
    endfunction

endpackage

// ----- hdl/pfc_if.sv -----
// Valid/ready channel interfaces for the prime factor counter.
// Depends on pfc_pkg for field widths.
interface pfc_in_if;
    logic                       valid;
    logic                       ready;
    logic [pfc_pkg::ARG_W-1:0]  value;
    logic                       start_of_set;

    modport source (output valid, output value, output start_of_set, input ready);
    modport sink   (input valid, input value, input start_of_set, output ready);
endinterface

interface pfc_out_if;
    logic                            valid;
    logic                            ready;
    logic [pfc_pkg::TOTAL_W-1:0]     factor_count;
    logic [pfc_pkg::DISTINCT_W-1:0]  distinct_count;
    logic [pfc_pkg::TOTAL_W-1:0]     best_factor_count;
    logic [pfc_pkg::ARG_W-1:0]       best_factor_value;
    logic [pfc_pkg::DISTINCT_W-1:0]  best_distinct_count;
    logic [pfc_pkg::ARG_W-1:0]       best_distinct_value;

    modport source (output valid, output factor_count, output distinct_count,
                    output best_factor_count, output best_factor_value,
                    output best_distinct_count, output best_distinct_value,
                    input ready);
    modport sink   (input valid, input factor_count, input distinct_count,
                    input best_factor_count, input best_factor_value,
                    input best_distinct_count, input best_distinct_value,
                    output ready);
endinterface

// ----- hdl/pfc_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
// Depends on pfc_pkg (t_div_stat).
module pfc_div #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output pfc_pkg::t_div_stat    o_stat,
    output logic [VALUE_BITS-1:0] o_quo,
    output logic [VALUE_BITS-1:0] o_rem
);
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_den;

    logic [VALUE_BITS:0]   w_shift;
    logic [VALUE_BITS:0]   w_diff;
    logic                  w_fit;

    assign w_shift = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(VALUE_BITS);
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_quo <= {r_quo[VALUE_BITS-2:0], w_fit};
            r_rem <= w_fit ? w_diff[VALUE_BITS-1:0] : w_shift[VALUE_BITS-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;
endmodule

// ----- hdl/pfc_core.sv -----
// Trial-division sequencer: drives the shared divider and counts factors.
// Depends on pfc_pkg and pfc_div.
module pfc_core #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_ack,
    output pfc_pkg::t_core_stat   o_stat
);
    pfc_pkg::t_core_state r_state, n_state;

    logic [VALUE_BITS-1:0]          r_n;
    logic [VALUE_BITS-1:0]          r_div;
    logic                           r_found;   // current divisor already counted
    logic [pfc_pkg::TOTAL_W-1:0]    r_total;
    logic [pfc_pkg::DISTINCT_W-1:0] r_distinct;

    logic                  w_div_start;
    pfc_pkg::t_div_stat    w_div_stat;
    logic [VALUE_BITS-1:0] w_quo;
    logic [VALUE_BITS-1:0] w_rem;
    logic                  w_n_gt1;
    logic                  w_loop_ok;
    logic                  w_exact;

    pfc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_n),
        .i_divisor  (r_div),
        .o_stat     (w_div_stat),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    assign w_n_gt1   = (r_n > VALUE_BITS'(1));
    assign w_loop_ok = w_n_gt1 && (r_div <= w_quo);
    assign w_exact   = (w_rem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfc_pkg::S_IDLE:   if (i_start) n_state = pfc_pkg::S_ISSUE;
            pfc_pkg::S_ISSUE:  n_state = pfc_pkg::S_WAIT;
            pfc_pkg::S_WAIT:   if (w_div_stat.done) n_state = pfc_pkg::S_EVAL;
            pfc_pkg::S_EVAL: begin
                if (!r_found && !w_loop_ok) begin
                    n_state = pfc_pkg::S_FINISH;
                end else begin
                    n_state = pfc_pkg::S_ISSUE;
                end
            end
            pfc_pkg::S_FINISH: n_state = pfc_pkg::S_DONE;
            pfc_pkg::S_DONE:   if (i_ack) n_state = pfc_pkg::S_IDLE;
            default:           n_state = pfc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_div_start          = (r_state == pfc_pkg::S_ISSUE);
        o_stat.busy          = (r_state != pfc_pkg::S_IDLE);
        o_stat.done          = (r_state == pfc_pkg::S_DONE);
        o_stat.factor_count  = r_total;
        o_stat.distinct_count = r_distinct;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pfc_pkg::S_IDLE: begin
                if (i_start) begin
                    r_n        <= i_value;
                    r_div      <= VALUE_BITS'(pfc_pkg::FIRST_DIVISOR);
                    r_found    <= 1'b0;
                    r_total    <= '0;
                    r_distinct <= '0;
                end
            end
            pfc_pkg::S_EVAL: begin
                if (r_found) begin
                    // repeated division by the same prime
                    if (w_exact) begin
                        r_n     <= w_quo;
                        r_total <= pfc_pkg::inc_total(r_total);
                    end else begin
                        r_found <= 1'b0;
                        r_div   <= r_div + 1'b1;
                    end
                end else if (w_loop_ok) begin
                    if (w_exact) begin
                        r_n        <= w_quo;
                        r_total    <= pfc_pkg::inc_total(r_total);
                        r_distinct <= pfc_pkg::inc_distinct(r_distinct);
                        r_found    <= 1'b1;
                    end else begin
                        r_div <= r_div + 1'b1;
                    end
                end
            end
            pfc_pkg::S_FINISH: begin
                // leftover cofactor above one is a prime
                if (w_n_gt1) begin
                    r_total    <= pfc_pkg::inc_total(r_total);
                    r_distinct <= pfc_pkg::inc_distinct(r_distinct);
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ----- hdl/prime_factor_counter_top.sv -----
// Prime factor counter: trial division with a shared divider, running maxima.
// Depends on pfc_pkg, pfc_if (pfc_in_if, pfc_out_if) and pfc_core.
//
// One value is taken per transfer and factored by trial division with
// divisors 2, 3, 4, ... up to the square root of the remaining cofactor.
// Each trial starts the shared restoring divider, waits for its result
// and evaluates it; each prime factor found costs one more trial per
// repeat. The number of trials is data dependent: a few for small or
// smooth values, up to about sqrt(value) for a prime or a value with a
// large prime cofactor (around 46k trials for the worst 31-bit values).
// The core takes one value at a time; i_in.ready is high only while it
// is idle. The result sits in an output register, so a new value is
// taken while the last result waits.
// Each result carries the factor count with multiplicity, the distinct
// count, and the running maxima of both with the first value that reached
// them (ties keep the earlier value). start_of_set clears the maxima
// before its own value is counted. Values 0 and 1 have no factors. Only
// the low VALUE_BITS bits of the value are factored.
module prime_factor_counter_top #(
    parameter int VALUE_BITS = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfc_in_if.sink       i_in,
    pfc_out_if.source    o_out
);
    localparam int AW = pfc_pkg::ARG_W;
    localparam int TW = pfc_pkg::TOTAL_W;
    localparam int DW = pfc_pkg::DISTINCT_W;

    pfc_pkg::t_core_stat w_stat;
    logic                w_in_xfer;
    logic                w_slot_free;
    logic                w_ack;
    logic                w_new_total;
    logic                w_new_distinct;

    // value as the core sees it, and as it is reported
    logic [VALUE_BITS-1:0] w_value;
    logic [AW-1:0]         r_arg;

    // running maxima
    logic [TW-1:0] r_max_total;
    logic [AW-1:0] r_max_total_arg;
    logic [DW-1:0] r_max_distinct;
    logic [AW-1:0] r_max_distinct_arg;

    // output register
    logic          r_out_valid;
    logic [TW-1:0] r_out_total;
    logic [DW-1:0] r_out_distinct;
    logic [TW-1:0] r_out_best_total;
    logic [AW-1:0] r_out_best_total_arg;
    logic [DW-1:0] r_out_best_distinct;
    logic [AW-1:0] r_out_best_distinct_arg;

    assign w_value     = VALUE_BITS'(i_in.value);
    assign i_in.ready  = !w_stat.busy;
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_ack       = w_stat.done && w_slot_free;

    // a strictly larger count takes over; ties keep the stored value
    assign w_new_total    = (w_stat.factor_count > r_max_total);
    assign w_new_distinct = (w_stat.distinct_count > r_max_distinct);

    pfc_core #(.VALUE_BITS(VALUE_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer),
        .i_value (w_value),
        .i_ack   (w_ack),
        .o_stat  (w_stat)
    );

    // reported value: masked to VALUE_BITS, then fitted to the field
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_arg <= AW'(w_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_total        <= '0;
            r_max_total_arg    <= '0;
            r_max_distinct     <= '0;
            r_max_distinct_arg <= '0;
        end else if (w_in_xfer && i_in.start_of_set) begin
            // core is idle here, so no update can collide with the clear
            r_max_total        <= '0;
            r_max_total_arg    <= '0;
            r_max_distinct     <= '0;
            r_max_distinct_arg <= '0;
        end else if (w_ack) begin
            if (w_new_total) begin
                r_max_total     <= w_stat.factor_count;
                r_max_total_arg <= r_arg;
            end
            if (w_new_distinct) begin
                r_max_distinct     <= w_stat.distinct_count;
                r_max_distinct_arg <= r_arg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_total    <= w_stat.factor_count;
            r_out_distinct <= w_stat.distinct_count;
            r_out_best_total        <= w_new_total ? w_stat.factor_count : r_max_total;
            r_out_best_total_arg    <= w_new_total ? r_arg : r_max_total_arg;
            r_out_best_distinct     <= w_new_distinct ? w_stat.distinct_count
                                                      : r_max_distinct;
            r_out_best_distinct_arg <= w_new_distinct ? r_arg : r_max_distinct_arg;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.factor_count        = r_out_total;
    assign o_out.distinct_count      = r_out_distinct;
    assign o_out.best_factor_count   = r_out_best_total;
    assign o_out.best_factor_value   = r_out_best_total_arg;
    assign o_out.best_distinct_count = r_out_best_distinct;
    assign o_out.best_distinct_value = r_out_best_distinct_arg;
endmodule

// ----- hdl/pfc_checker.sv -----
// Port-level checker for prime_factor_counter_top, attached by bind.
// Depends on pfc_pkg and prime_factor_counter_top_assert.svh.
`include "prime_factor_counter_top_assert.svh"

module pfc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [pfc_pkg::TOTAL_W-1:0]     i_factor_count,
    input logic [pfc_pkg::DISTINCT_W-1:0]  i_distinct_count,
    input logic [pfc_pkg::TOTAL_W-1:0]     i_best_factor_count,
    input logic [pfc_pkg::DISTINCT_W-1:0]  i_best_distinct_count
);
    logic w_out_stall;
    logic w_in_xfer;

    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_in_xfer   = i_in_valid && i_in_ready;

    // stalled result stays valid and keeps its factor count and best factor count
    `PFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall,
        i_out_valid && $stable(i_factor_count) && $stable(i_best_factor_count))

    // one value at a time: busy right after a transfer
    `PFC_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, w_in_xfer, !i_in_ready)

    // running maxima cover the current item
    `PFC_ASSERT_SAME(a_best_total, i_clk, i_rst_n, i_out_valid,
        i_best_factor_count >= i_factor_count)
    `PFC_ASSERT_SAME(a_best_distinct, i_clk, i_rst_n, i_out_valid,
        i_best_distinct_count >= i_distinct_count)

    // every distinct prime counts at least once
    `PFC_ASSERT_SAME(a_distinct_le_total, i_clk, i_rst_n, i_out_valid,
        i_distinct_count <= i_factor_count)
endmodule

bind prime_factor_counter_top pfc_checker u_pfc_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_factor_count        (o_out.factor_count),
    .i_distinct_count      (o_out.distinct_count),
    .i_best_factor_count   (o_out.best_factor_count),
    .i_best_distinct_count (o_out.best_distinct_count)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for prime_factor_counter_top.
// Depends on pfc_pkg, pfc_if and the RTL under hdl; drives a directed table,
// then smooth-ish random values, and scores every result (typed-in or predicted).
module tb_top;

    localparam int IDLE_PCT     = 8;    // chance of an idle cycle on either side
    localparam int RANDOM_ITEMS = 100;
    localparam int N_DIRECTED   = 23;
    localparam int DRAIN_CYCLES = 40;   // quiet time after the last result

    // One result transfer, in port order.
    typedef struct packed {
        logic [pfc_pkg::TOTAL_W-1:0]    factor_count;
        logic [pfc_pkg::DISTINCT_W-1:0] distinct_count;
        logic [pfc_pkg::TOTAL_W-1:0]    best_factor_count;
        logic [pfc_pkg::ARG_W-1:0]      best_factor_value;
        logic [pfc_pkg::DISTINCT_W-1:0] best_distinct_count;
        logic [pfc_pkg::ARG_W-1:0]      best_distinct_value;
    } t_factor_result;

    // Directed stimulus row; hand_checked rows carry a typed-in result.
    typedef struct packed {
        logic [pfc_pkg::ARG_W-1:0] value;
        logic                      start_of_set;
        logic                      hand_checked;
        t_factor_result            result;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;   // high during the stretch where neither side idles

    pfc_in_if  in_ch ();
    pfc_out_if out_ch ();

    prime_factor_counter_top #(
        .VALUE_BITS (pfc_pkg::ARG_W)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor copy of the running maxima.
    logic [pfc_pkg::TOTAL_W-1:0]    top_factor_count;
    logic [pfc_pkg::ARG_W-1:0]      top_factor_value;
    logic [pfc_pkg::DISTINCT_W-1:0] top_distinct_count;
    logic [pfc_pkg::ARG_W-1:0]      top_distinct_value;

    t_factor_result pending_counts[$];
    int unsigned    error_count = 0;
    int unsigned    result_index = 0;

    // Directed table. Typed-in rows are the ones readable by eye: values with
    // no factors, a cleared set, a power of two, the widest primorial and the
    // largest value (a prime, which also drives the longest division run).
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{31'd0,          1'b0, 1'b1, '{5'd0, 4'd0, 5'd0, 31'd0, 4'd0, 31'd0}},
        '{31'd1,          1'b0, 1'b1, '{5'd0, 4'd0, 5'd0, 31'd0, 4'd0, 31'd0}},
        '{31'd2,          1'b0, 1'b0, '0},
        '{31'd3,          1'b0, 1'b0, '0},   // tie, 2 stays
        '{31'd12,         1'b0, 1'b0, '0},
        '{31'd18,         1'b0, 1'b0, '0},   // tie on both counts, 12 stays
        '{31'd1,          1'b0, 1'b0, '0},   // no factors, maxima held
        '{31'd0,          1'b1, 1'b1, '{5'd0, 4'd0, 5'd0, 31'd0, 4'd0, 31'd0}},
        '{31'd1073741824, 1'b1, 1'b1,
          '{5'd30, 4'd1, 5'd30, 31'd1073741824, 4'd1, 31'd1073741824}},
        '{31'd1073741823, 1'b0, 1'b0, '0},
        '{31'd223092870,  1'b0, 1'b0, '0},
        '{31'd223092870,  1'b1, 1'b1,
          '{5'd9, 4'd9, 5'd9, 31'd223092870, 4'd9, 31'd223092870}},
        '{31'd2147483647, 1'b1, 1'b1,
          '{5'd1, 4'd1, 5'd1, 31'd2147483647, 4'd1, 31'd2147483647}},
        '{31'd2147483646, 1'b0, 1'b0, '0},
        '{31'd65521,      1'b0, 1'b0, '0},
        '{31'd1536,       1'b0, 1'b0, '0},
        '{31'd1,          1'b1, 1'b1, '{5'd0, 4'd0, 5'd0, 31'd0, 4'd0, 31'd0}},
        '{31'd4,          1'b0, 1'b0, '0},
        '{31'd6,          1'b0, 1'b0, '0},
        '{31'd6,          1'b0, 1'b0, '0},
        '{31'd1431655765, 1'b0, 1'b0, '0},   // 0x55555555
        '{31'd715827882,  1'b0, 1'b0, '0},   // 0x2AAAAAAA
        '{31'd1073741824, 1'b0, 1'b0, '0}
    };

    // Trial division with divisors 2, 3, 4, ... while div*div <= cofactor.
    // Counts saturate at the field maximum.
    function automatic void count_factors(
        input  logic [pfc_pkg::ARG_W-1:0]      v,
        output logic [pfc_pkg::TOTAL_W-1:0]    total,
        output logic [pfc_pkg::DISTINCT_W-1:0] distinct);
        longint unsigned n;
        longint unsigned div;
        n        = v;
        div      = pfc_pkg::FIRST_DIVISOR;
        total    = '0;
        distinct = '0;
        while (n > 1 && div <= n / div) begin
            if (n % div == 0) begin
                if (distinct != pfc_pkg::DISTINCT_MAX) distinct = distinct + 1'b1;
                while (n % div == 0) begin
                    n = n / div;
                    if (total != pfc_pkg::TOTAL_MAX) total = total + 1'b1;
                end
            end
            div++;
        end
        if (n > 1) begin
            if (distinct != pfc_pkg::DISTINCT_MAX) distinct = distinct + 1'b1;
            if (total != pfc_pkg::TOTAL_MAX) total = total + 1'b1;
        end
    endfunction

    // Result for one accepted value; updates the running maxima.
    function automatic t_factor_result predict_counts(
        input logic [pfc_pkg::ARG_W-1:0] v,
        input logic                      sos);
        t_factor_result r;
        if (sos) begin
            top_factor_count   = '0;
            top_factor_value   = '0;
            top_distinct_count = '0;
            top_distinct_value = '0;
        end
        count_factors(v, r.factor_count, r.distinct_count);
        // strictly larger only: ties keep the earlier value
        if (r.factor_count > top_factor_count) begin
            top_factor_count = r.factor_count;
            top_factor_value = v;
        end
        if (r.distinct_count > top_distinct_count) begin
            top_distinct_count = r.distinct_count;
            top_distinct_value = v;
        end
        r.best_factor_count   = top_factor_count;
        r.best_factor_value   = top_factor_value;
        r.best_distinct_count = top_distinct_count;
        r.best_distinct_value = top_distinct_value;
        return r;
    endfunction

    // Random values whose trial division stays short: every prime factor but
    // the largest is small, and the largest is below 2^16, so a run needs at
    // most a few hundred trials. Still spans all 31 bits.
    function automatic logic [pfc_pkg::ARG_W-1:0] random_value();
        longint unsigned acc;
        longint unsigned f;
        longint unsigned ceiling;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            acc = $urandom_range(300);                  // hits 0, 1 and small primes
        end else if (pick < 30) begin
            acc = longint'($urandom_range(65535, 1)) << $urandom_range(15);
        end else begin
            ceiling = 64'd1 << $urandom_range(31, 4);
            acc     = 1;
            repeat (40) begin
                f = $urandom_range(64, 2);
                if (acc * f < ceiling) acc = acc * f;
            end
            f = $urandom_range(65535, 2);
            if ($urandom_range(1) == 1 && acc * f < ceiling) acc = acc * f;
        end
        return acc[pfc_pkg::ARG_W-1:0];
    endfunction

    // Present one value, hold it until the transfer, and queue its result.
    // ready is sampled at the falling edge so the decision is settled well
    // before the rising edge that completes the transfer.
    task automatic send_value(input logic [pfc_pkg::ARG_W-1:0] v, input logic sos,
                              input logic hand_checked, input t_factor_result typed);
        t_factor_result pred;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.value        <= v;
        in_ch.start_of_set <= sos;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        pred = predict_counts(v, sos);
        pending_counts.push_back(hand_checked ? typed : pred);
        @(posedge clk);
    endtask

    // Result sink: random back-pressure except in the steady stretch.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Scoreboard: a transfer is decided at the falling edge and lands at the
    // next rising edge; outputs are stable in between.
    always @(negedge clk) begin
        t_factor_result got;
        t_factor_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.factor_count, out_ch.distinct_count,
                    out_ch.best_factor_count, out_ch.best_factor_value,
                    out_ch.best_distinct_count, out_ch.best_distinct_value};
            if (pending_counts.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result %0d arrived with nothing outstanding", result_index);
            end else begin
                want = pending_counts.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("result %0d mismatch", result_index);
                        $display("  expected: fc=%0d dc=%0d best_fc=%0d/%0d best_dc=%0d/%0d",
                                 want.factor_count, want.distinct_count,
                                 want.best_factor_count, want.best_factor_value,
                                 want.best_distinct_count, want.best_distinct_value);
                        $display("  actual:   fc=%0d dc=%0d best_fc=%0d/%0d best_dc=%0d/%0d",
                                 got.factor_count, got.distinct_count,
                                 got.best_factor_count, got.best_factor_value,
                                 got.best_distinct_count, got.best_distinct_value);
                    end
                end
            end
            result_index++;
        end
    end

    // Stimulus and verdict.
    initial begin
        rst_n              = 1'b0;
        steady             = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.value        = '0;
        in_ch.start_of_set = 1'b0;
        top_factor_count   = '0;
        top_factor_value   = '0;
        top_distinct_count = '0;
        top_distinct_value = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; includes the largest prime, the one slow item
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_value(directed_rows[i].value, directed_rows[i].start_of_set,
                       directed_rows[i].hand_checked, directed_rows[i].result);
        end

        // random part, mostly short sets; one stretch runs without idles
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            steady <= (k >= 40 && k < 70);
            send_value(random_value(), ($urandom_range(9) == 0), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;
        steady      <= 1'b0;

        while (pending_counts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: fails the test if the run does not finish in time.
    initial begin
        #80_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_if.sv
hdl/pfc_div.sv
hdl/pfc_core.sv
hdl/prime_factor_counter_top.sv
hdl/pfc_checker.sv
sim/tb_top.sv
